// ===== src/assert_macros.svh =====
// Assertion macros shared by the CRC appender modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/fcrc_pkg.sv =====
// Shared types, constants and the CRC byte function of the CRC appender.
`timescale 1ns / 1ps

package fcrc_pkg;

    localparam logic [15:0] CRC_SEED           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'hA001;
    localparam logic [7:0]  START_MARKER_RESET = 8'hAA;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One queued byte with the CRC that includes it
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_frame;
        logic [15:0] crc;
    } fcrc_entry_t;

    // Advance the reflected CRC-16 by one byte, least significant bit first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/fcrc_front.sv =====
// Front end: takes input beats, checks the start byte, runs the CRC, fills the queue.
`timescale 1ns / 1ps

module fcrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output fcrc_pkg::fcrc_entry_t q_entry
);
    import fcrc_pkg::*;

    logic [7:0]  start_marker_reg, start_marker_next;
    logic [15:0] crc_reg, crc_next;
    logic        expect_first_reg, expect_first_next;
    logic        discarding_reg, discarding_next;

    logic        accept;
    logic        drop;
    logic [15:0] crc_seed;
    logic [15:0] crc_new;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // Classify the beat: a frame start with the wrong byte drops the whole frame
    assign drop     = expect_first_reg ? (s_tdata != start_marker_reg) : discarding_reg;
    assign crc_seed = expect_first_reg ? CRC_SEED : crc_reg;
    assign crc_new  = crc16_byte(crc_seed, s_tdata);

    assign q_push               = accept && !drop;
    assign q_entry.data_byte    = s_tdata;
    assign q_entry.end_of_frame = s_tlast;
    assign q_entry.crc          = crc_new;

    // Next frame state
    always_comb
    begin
        start_marker_next = cfg_valid ? cfg_data : start_marker_reg;
        crc_next          = crc_reg;
        expect_first_next = expect_first_reg;
        discarding_next   = discarding_reg;
        if (accept)
        begin
            expect_first_next = s_tlast;
            if (drop)
            begin
                discarding_next = !s_tlast;
                crc_next        = CRC_SEED;
            end
            else
            begin
                discarding_next = 1'b0;
                crc_next        = s_tlast ? CRC_SEED : crc_new;
            end
        end
    end

    // Hold frame state and the start byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            crc_reg          <= CRC_SEED;
            expect_first_reg <= 1'b1;
            discarding_reg   <= 1'b0;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            crc_reg          <= crc_next;
            expect_first_reg <= expect_first_next;
            discarding_reg   <= discarding_next;
        end
    end

endmodule

// ===== src/fcrc_fifo.sv =====
// Short queue of classified bytes between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcrc_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fcrc_pkg::fcrc_entry_t wr_entry,
    output logic                  full,
    input  logic                  pop,
    output fcrc_pkg::fcrc_entry_t rd_entry,
    output logic                  empty
);
    import fcrc_pkg::*;

    fcrc_entry_t        mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full     = (count_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `ASSERT_NEVER(a_push_when_full, push && full, "queue written while full")
    `ASSERT_NEVER(a_pop_when_empty, pop && empty, "queue read while empty")

endmodule

// ===== src/fcrc_back.sv =====
// Back end: sends queued bytes and appends the two CRC bytes after each frame.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  fcrc_pkg::fcrc_entry_t q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import fcrc_pkg::*;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;
    logic        load;

    // Output register is free when empty or being taken this cycle
    assign load  = !m_tvalid_reg || m_tready;
    assign q_pop = load && (phase_reg == PH_DATA) && !q_empty;

    always_comb
    begin
        phase_next    = phase_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    if (!q_empty)
                    begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = q_entry.data_byte;
                        m_tuser_next  = 1'b0;
                        m_tlast_next  = 1'b0;
                        crc_next      = q_entry.crc;
                        if (q_entry.end_of_frame)
                        begin
                            phase_next = PH_CRC_LO;
                        end
                    end
                end
                PH_CRC_LO:
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = crc_reg[7:0];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b0;
                    phase_next    = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = crc_reg[15:8];
                    m_tuser_next  = 1'b1;
                    m_tlast_next  = 1'b1;
                    phase_next    = PH_DATA;
                end
                default:
                begin
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    // Hold phase, CRC and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DATA;
            crc_reg      <= CRC_SEED;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_CLK(a_hi_follows_lo,
        (m_tvalid && m_tready && m_tuser && !m_tlast) |=> (m_tvalid && m_tuser && m_tlast),
        "CRC high byte does not follow CRC low byte")
    `ASSERT_NEVER(a_pop_in_crc, q_pop && (phase_reg != PH_DATA),
        "queue popped while CRC bytes pending")

endmodule

// ===== src/frame_crc16_appender_top.sv =====
// Top level of the frame CRC-16 appender.
`timescale 1ns / 1ps
// Usage:
//   Input stream s_*: one frame byte per beat, s_tlast on the final byte.
//   Output stream m_*: every byte of a frame that opens with the start byte,
//   followed by CRC-16 (poly 0xA001 reflected, seed 0xFFFF) low byte then high
//   byte; m_tuser marks the two CRC beats, m_tlast marks the CRC high byte.
//   A frame whose first byte differs from the start byte is dropped whole.
//   Config channel cfg_*: writes the start byte; write only while idle,
//   it takes effect at the next frame start. cfg_ready is always high.
// Timing:
//   An accepted byte is written into the queue, then moved into the output
//   register on m_* when that register is free. Input takes one beat per
//   cycle while the 4-entry queue has room; output sends one beat per cycle
//   while m_tready is high and a beat is waiting, so a frame of N bytes gives
//   N+2 output beats, and the output port sets the sustained rate.
// Reset (rst_n low, async): queue and output empty, start byte 0xAA, next
//   byte is a frame start. When m_tready is low the output beat holds and the
//   queue fills, then s_tready drops.
module frame_crc16_appender_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,      // start_marker
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // data_byte[7:0]
    input  logic       s_tlast,       // end_of_frame
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // out_byte[7:0]
    output logic       m_tuser,       // is_check_byte
    output logic       m_tlast        // frame_last
);
    import fcrc_pkg::*;

    fcrc_entry_t wr_entry;
    fcrc_entry_t rd_entry;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    fcrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    fcrc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    fcrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (rd_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
